// ===== design/html_entity_to_utf8_decoder_macros.svh =====
// assertion macros for the html entity decoder checker
// no dependencies; included by the checker file
`ifndef HTML_ENTITY_TO_UTF8_DECODER_MACROS_SVH
`define HTML_ENTITY_TO_UTF8_DECODER_MACROS_SVH

// same-cycle implication, disabled during reset
`define HEUD_ASSERT_NOW(name, clock, reset_n, cond, expr) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (cond) |-> (expr)) \
        else $error("heud check failed");

// next-cycle implication, disabled during reset
`define HEUD_ASSERT_NEXT(name, clock, reset_n, cond, expr) \
    name: assert property (@(posedge clock) disable iff (!reset_n) (cond) |=> (expr)) \
        else $error("heud check failed");

`endif

// ===== design/heud_pkg.sv =====
// shared types, constants and helper functions of the html entity decoder
// used by heud_ctrl, heud_dpath and the top level; no dependencies
package heud_pkg;

    // byte codes
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_QMARK = 8'h3F;

    // code point limits
    localparam int         CP_W     = 21;
    localparam int         ACC_W    = CP_W + 4;
    localparam logic [CP_W-1:0] CP_ASCII_LIM = 21'h000080;
    localparam logic [CP_W-1:0] CP_2B_MAX    = 21'h0007FF;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_3B_MAX    = 21'h00FFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [CP_W-1:0] CP_SAT       = 21'h110000;

    // named references: lt gt amp quot apos nbsp, text packed msb first
    localparam int NUM_NAMES = 6;
    localparam logic [31:0] NAME_TEXT [NUM_NAMES] = '{
        32'h6C74_0000, 32'h6774_0000, 32'h616D_7000,
        32'h7175_6F74, 32'h6170_6F73, 32'h6E62_7370
    };
    localparam logic [2:0] NAME_LEN [NUM_NAMES] = '{
        3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [7:0] NAME_VALUE [NUM_NAMES] = '{
        8'h3C, 8'h3E, 8'h26, 8'h22, 8'h27, 8'h20
    };

    // datapath commands
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,
        OP_PASS,
        OP_OPEN,
        OP_HOLD,
        OP_FAIL,
        OP_RESOLVE,
        OP_EMIT,
        OP_FINISH
    } op_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic drained;
        logic in_ref;
        logic end_flag;
        logic is_amp;
        logic is_semi;
        logic is_nul;
        logic hold_full;
        logic ref_known;
        logic emit_ok;
        logic seq_last;
    } status_t;

    function automatic logic [7:0] name_char(input logic [2:0] idx, input logic [1:0] pos);
        logic [31:0] txt;
        logic [7:0]  ch;
        txt = NAME_TEXT[idx];
        unique case (pos)
            2'd0:    ch = txt[31:24];
            2'd1:    ch = txt[23:16];
            2'd2:    ch = txt[15:8];
            default: ch = txt[7:0];
        endcase
        return ch;
    endfunction

    // bit 4 set when the byte is a digit of the current base
    function automatic logic [4:0] digit_val(input logic [7:0] b, input logic hex);
        logic [7:0] diff;
        logic [4:0] res;
        res = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            diff = b - 8'h30;
            res  = {1'b1, diff[3:0]};
        end else if (hex && b >= 8'h61 && b <= 8'h66) begin
            diff = b - 8'h57;
            res  = {1'b1, diff[3:0]};
        end else if (hex && b >= 8'h41 && b <= 8'h46) begin
            diff = b - 8'h37;
            res  = {1'b1, diff[3:0]};
        end
        return res;
    endfunction

    function automatic logic [2:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [2:0] n;
        if (cp == '0 || cp > CP_MAX || cp < CP_ASCII_LIM) begin
            n = 3'd1;
        end else if (cp <= CP_2B_MAX) begin
            n = 3'd2;
        end else if (cp <= CP_3B_MAX) begin
            n = 3'd3;
        end else begin
            n = 3'd4;
        end
        return n;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp, input logic [1:0] idx);
        logic [7:0] b;
        if (cp == '0 || cp > CP_MAX) begin
            b = CH_QMARK;
        end else if (cp < CP_ASCII_LIM) begin
            b = cp[7:0];
        end else if (cp <= CP_2B_MAX) begin
            b = (idx == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
        end else if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
            unique case (idx)
                2'd0:    b = 8'hEF;
                2'd1:    b = 8'hBF;
                default: b = 8'hBD;
            endcase
        end else if (cp <= CP_3B_MAX) begin
            unique case (idx)
                2'd0:    b = {4'b1110, cp[15:12]};
                2'd1:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[5:0]};
            endcase
        end else begin
            unique case (idx)
                2'd0:    b = {5'b11110, cp[20:18]};
                2'd1:    b = {2'b10, cp[17:12]};
                2'd2:    b = {2'b10, cp[11:6]};
                default: b = {2'b10, cp[5:0]};
            endcase
        end
        return b;
    endfunction

endpackage

// ===== design/html_entity_to_utf8_decoder.sv =====
// top level of the html character reference decoder, byte stream to utf-8
// instantiates heud_ctrl and heud_dpath; uses heud_pkg
//
//   channel  direction  handshake                 payload
//   text     in         text_valid / text_stall   text_byte, end_of_text
//   result   out        result_valid / result_stall  out_byte, last, stream_done
//
// a transaction is a load step, a scan step per byte (the new byte and every held
// byte replayed after a failed reference), a step per failed reference for its '&',
// a step per utf-8 byte of a resolved reference and a finish step
// result_stall holds the sequencer only when a byte must move on while the output
// register and the pending byte are both occupied
// rst_n clears pointers, reference state and valid flags; no clearing pass
module html_entity_to_utf8_decoder
    import heud_pkg::*;
#(
    parameter int WINDOW_BYTES = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       text_valid,
    output logic       text_stall,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       stream_done
);

    // command from the controller, status back from the datapath
    op_t     op;
    status_t status;

    // controller: idle / scan / utf-8 emit sequencer; stalls text while busy
    heud_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .text_valid (text_valid),
        .text_stall (text_stall),
        .status     (status),
        .op         (op)
    );

    // datapath: replay window of WINDOW_BYTES entries, matchers, output stage
    heud_dpath #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .op           (op),
        .status       (status),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .last         (last),
        .stream_done  (stream_done)
    );

endmodule

// ===== design/heud_ctrl.sv =====
// controller state machine of the html entity decoder
// depends on heud_pkg; drives the datapath by command, reads its status
module heud_ctrl
    import heud_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    text_valid,
    output logic    text_stall,
    input  status_t status,
    output op_t     op
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PROC,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        op         = OP_NOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (text_valid)
                begin
                    op         = OP_LOAD;
                    state_next = S_PROC;
                end
            end
            S_PROC:
            begin
                if (status.drained)
                begin
                    // end of text flushes an open reference
                    if (status.end_flag && status.in_ref)
                    begin
                        if (status.emit_ok)
                            op = OP_FAIL;
                    end
                    else if (status.emit_ok)
                    begin
                        op         = OP_FINISH;
                        state_next = S_IDLE;
                    end
                end
                else if (!status.in_ref)
                begin
                    if (status.is_amp)
                        op = OP_OPEN;
                    else if (status.emit_ok)
                        op = OP_PASS;
                end
                else if (status.is_semi && status.ref_known)
                begin
                    op         = OP_RESOLVE;
                    state_next = S_EMIT;
                end
                else if (status.is_semi || status.is_nul || status.hold_full)
                begin
                    if (status.emit_ok)
                        op = OP_FAIL;
                end
                else
                begin
                    op = OP_HOLD;
                end
            end
            S_EMIT:
            begin
                if (status.emit_ok)
                begin
                    op = OP_EMIT;
                    if (status.seq_last)
                        state_next = S_PROC;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign text_stall = (state_reg != S_IDLE);

endmodule

// ===== design/heud_dpath.sv =====
// datapath of the html entity decoder: replay window, reference matching,
// code point accumulation, utf-8 sequencing and output register; uses heud_pkg
module heud_dpath
    import heud_pkg::*;
#(
    parameter int WINDOW_BYTES = 12
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  op_t        op,
    output status_t    status,
    input  logic [7:0] text_byte,
    input  logic       end_of_text,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] out_byte,
    output logic       last,
    output logic       stream_done
);

    localparam int DEPTH    = WINDOW_BYTES;
    localparam int HOLD_CAP = WINDOW_BYTES - 1;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(HOLD_CAP + 1);
    localparam int CMP_W    = (CNT_W > 3) ? CNT_W : 3;

    logic [7:0]       win_reg [DEPTH];
    logic [PTR_W-1:0] rp_reg, rp_next, wp_reg, wp_next, sp_reg, sp_next;
    logic [PTR_W-1:0] rp_inc, wp_inc;
    logic [CNT_W-1:0] hc_reg, hc_next;
    logic             in_ref_reg, in_ref_next;
    logic             end_reg, end_next;

    logic [NUM_NAMES-1:0] name_ok_reg, name_ok_next, name_step, name_full;
    logic             num_reg, num_next, hex_reg, hex_next, stop_reg, stop_next;
    logic [CP_W-1:0]  acc_reg, acc_next;
    logic [CP_W-1:0]  emit_cp_reg, emit_cp_next;
    logic [1:0]       emit_idx_reg, emit_idx_next;

    logic             pend_valid_reg, pend_valid_next;
    logic [7:0]       pend_byte_reg, pend_byte_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_last_reg, out_last_next;
    logic             out_done_reg, out_done_next;

    logic [7:0]       cur_byte;
    logic [4:0]       dig;
    logic [ACC_W-1:0] acc_mul, acc_sum;
    logic [CP_W-1:0]  acc_step;
    logic [CP_W-1:0]  resolved_cp;
    logic             any_named;
    logic             emit_req;
    logic [7:0]       emit_byte;
    logic             out_ready;
    logic [2:0]       seq_len;

    assign rp_inc   = (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign wp_inc   = (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign cur_byte = win_reg[rp_reg];

    // per-name prefix match for the byte being held, and full match at ';'
    always_comb
    begin
        for (int n = 0; n < NUM_NAMES; n++)
        begin
            name_step[n] = name_ok_reg[n]
                && (CMP_W'(hc_reg) < CMP_W'(NAME_LEN[n]))
                && (cur_byte == name_char(3'(n), hc_reg[1:0]));
            name_full[n] = name_ok_reg[n] && (CMP_W'(hc_reg) == CMP_W'(NAME_LEN[n]));
        end
    end

    always_comb
    begin
        resolved_cp = acc_reg;
        for (int n = NUM_NAMES - 1; n >= 0; n--)
        begin
            if (name_full[n])
                resolved_cp = {13'd0, NAME_VALUE[n]};
        end
    end

    assign any_named = |name_full;

    // one digit step: times ten or sixteen plus digit, saturating
    assign dig      = digit_val(cur_byte, hex_reg);
    assign acc_mul  = hex_reg ? {acc_reg, 4'd0}
                              : ({1'b0, acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0});
    assign acc_sum  = acc_mul + {{(ACC_W - 4){1'b0}}, dig[3:0]};
    assign acc_step = (acc_sum > ACC_W'(CP_MAX)) ? CP_SAT : acc_sum[CP_W-1:0];

    always_comb
    begin
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        sp_next       = sp_reg;
        hc_next       = hc_reg;
        in_ref_next   = in_ref_reg;
        end_next      = end_reg;
        name_ok_next  = name_ok_reg;
        num_next      = num_reg;
        hex_next      = hex_reg;
        stop_next     = stop_reg;
        acc_next      = acc_reg;
        emit_cp_next  = emit_cp_reg;
        emit_idx_next = emit_idx_reg;
        unique case (op)
            OP_LOAD:
            begin
                wp_next  = wp_inc;
                end_next = end_of_text;
            end
            OP_PASS:
            begin
                rp_next = rp_inc;
            end
            OP_OPEN:
            begin
                rp_next      = rp_inc;
                sp_next      = rp_inc;
                hc_next      = '0;
                in_ref_next  = 1'b1;
                name_ok_next = '1;
                num_next     = 1'b0;
                hex_next     = 1'b0;
                stop_next    = 1'b0;
                acc_next     = '0;
            end
            OP_HOLD:
            begin
                rp_next      = rp_inc;
                hc_next      = hc_reg + 1'b1;
                name_ok_next = name_step;
                if (hc_reg == '0)
                begin
                    num_next = (cur_byte == CH_HASH);
                end
                else if (num_reg && !stop_reg)
                begin
                    if (hc_reg == CNT_W'(1) && (cur_byte == CH_X_LO || cur_byte == CH_X_UP))
                        hex_next = 1'b1;
                    else if (!dig[4])
                        stop_next = 1'b1;
                    else
                        acc_next = acc_step;
                end
            end
            OP_FAIL:
            begin
                // rescan from the first held byte
                rp_next     = sp_reg;
                hc_next     = '0;
                in_ref_next = 1'b0;
            end
            OP_RESOLVE:
            begin
                rp_next       = rp_inc;
                hc_next       = '0;
                in_ref_next   = 1'b0;
                emit_cp_next  = resolved_cp;
                emit_idx_next = 2'd0;
            end
            OP_EMIT:
            begin
                emit_idx_next = emit_idx_reg + 2'd1;
            end
            default:
            begin
            end
        endcase
    end

    // a pending byte waits until it is known whether it ends the transaction
    assign emit_req  = (op == OP_PASS) || (op == OP_FAIL) || (op == OP_EMIT);
    assign out_ready = !out_valid_reg || !result_stall;

    always_comb
    begin
        unique case (op)
            OP_PASS: emit_byte = cur_byte;
            OP_FAIL: emit_byte = CH_AMP;
            default: emit_byte = utf8_byte(emit_cp_reg, emit_idx_reg);
        endcase
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_done_next   = out_done_reg;
        if (emit_req)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                out_last_next  = 1'b0;
                out_done_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_byte_next  = emit_byte;
        end
        else if (op == OP_FINISH && pend_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_byte_next   = pend_byte_reg;
            out_last_next   = 1'b1;
            out_done_next   = end_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rp_reg         <= '0;
            wp_reg         <= '0;
            sp_reg         <= '0;
            hc_reg         <= '0;
            in_ref_reg     <= 1'b0;
            end_reg        <= 1'b0;
            emit_idx_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            rp_reg         <= rp_next;
            wp_reg         <= wp_next;
            sp_reg         <= sp_next;
            hc_reg         <= hc_next;
            in_ref_reg     <= in_ref_next;
            end_reg        <= end_next;
            emit_idx_reg   <= emit_idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op == OP_LOAD)
            win_reg[wp_reg] <= text_byte;
        name_ok_reg   <= name_ok_next;
        num_reg       <= num_next;
        hex_reg       <= hex_next;
        stop_reg      <= stop_next;
        acc_reg       <= acc_next;
        emit_cp_reg   <= emit_cp_next;
        pend_byte_reg <= pend_byte_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_done_reg  <= out_done_next;
    end

    assign seq_len = utf8_len(emit_cp_reg);

    assign status.drained   = (rp_reg == wp_reg);
    assign status.in_ref    = in_ref_reg;
    assign status.end_flag  = end_reg;
    assign status.is_amp    = (cur_byte == CH_AMP);
    assign status.is_semi   = (cur_byte == CH_SEMI);
    assign status.is_nul    = (cur_byte == CH_NUL);
    assign status.hold_full = (hc_reg == CNT_W'(HOLD_CAP - 1));
    assign status.ref_known = any_named || num_reg;
    assign status.emit_ok   = !pend_valid_reg || out_ready;
    assign status.seq_last  = ({1'b0, emit_idx_reg} == (seq_len - 3'd1));

    assign result_valid = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign last         = out_last_reg;
    assign stream_done  = out_done_reg;

endmodule

// ===== design/heud_checker.sv =====
// port-level checks of the html entity decoder, bound to the top level
// uses html_entity_to_utf8_decoder_macros.svh
`include "html_entity_to_utf8_decoder_macros.svh"

module heud_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       text_valid,
    input logic       text_stall,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] out_byte,
    input logic       last,
    input logic       stream_done
);

    // a stalled result stays put
    `HEUD_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(out_byte) && $stable(last) && $stable(stream_done))

    // the end of the stream is always the end of a transaction's results
    `HEUD_ASSERT_NOW(a_done_is_last, clk, rst_n, result_valid && stream_done, last)

    // after a text transaction the sequencer is busy
    `HEUD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, text_valid && !text_stall, text_stall)

endmodule

bind html_entity_to_utf8_decoder heud_checker u_heud_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_byte     (out_byte),
    .last         (last),
    .stream_done  (stream_done)
);

// ===== sim/html_entity_to_utf8_decoder_test.sv =====
`timescale 1ns / 1ps
// self-checking testbench for html_entity_to_utf8_decoder: directed rows, then random text
// needs only the decoder rtl (design/html_entity_to_utf8_decoder.sv, its submodules and heud_pkg.sv)
module html_entity_to_utf8_decoder_test;

    localparam int WINDOW_BYTES   = 12;
    localparam int HOLD_CAP       = WINDOW_BYTES - 1;
    localparam int OUT_CAP        = WINDOW_BYTES + 8;
    localparam int RANDOM_ITEMS   = 126;
    localparam int BY_MODEL       = -1;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int IDLE_PERCENT   = 15;

    localparam logic [7:0] AMP_CHAR   = 8'h26;
    localparam logic [7:0] SEMI_CHAR  = 8'h3B;
    localparam logic [7:0] HASH_CHAR  = 8'h23;
    localparam logic [7:0] NUL_CHAR   = 8'h00;
    localparam logic [7:0] X_LOWER    = 8'h78;
    localparam logic [7:0] X_UPPER    = 8'h58;
    localparam logic [7:0] QMARK_CHAR = 8'h3F;
    localparam logic [7:0] CASE_BIT   = 8'h20;

    localparam logic [31:0] CP_LIMIT     = 32'h0010FFFF;
    localparam logic [31:0] CP_SATURATED = 32'h00110000;

    // one text transaction, with an optional hand-written expectation
    typedef struct {
        logic [7:0]  value;
        logic        eot;
        int          n_known;
        logic [23:0] known;
    } text_item_t;

    // one expected output transaction
    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       done;
    } decoded_byte_t;

    typedef enum int {
        SEQ_PLAIN,
        SEQ_NAMED,
        SEQ_DECIMAL,
        SEQ_HEX,
        SEQ_TRAILING,
        SEQ_UNKNOWN,
        SEQ_OVERFLOW,
        SEQ_NUL,
        SEQ_CUT,
        SEQ_HUGE
    } seq_kind_t;

    logic       clk;
    logic       rst_n;
    logic       text_valid;
    logic       text_stall;
    logic [7:0] text_byte;
    logic       end_of_text;
    logic       result_valid;
    logic       result_stall;
    logic [7:0] out_byte;
    logic       last;
    logic       stream_done;

    html_entity_to_utf8_decoder #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_byte    (text_byte),
        .end_of_text  (end_of_text),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .out_byte     (out_byte),
        .last         (last),
        .stream_done  (stream_done)
    );

    // stimulus and scoreboard
    text_item_t    stim[$];
    decoded_byte_t pending_output[$];
    logic [7:0]    seq_bytes[$];
    int            next_item       = 0;
    int            directed_count  = 0;
    int            holdoff_at      = 32'h7FFFFFFF;
    int            pause_at        = 32'h7FFFFFFF;
    int            quiet_from      = 32'h7FFFFFFF;
    int            quiet_to        = 32'h7FFFFFFF;
    int            mismatches      = 0;
    int            results_checked = 0;
    int            streams         = 0;

    // no random idling on either side while the sender is in this stretch
    logic calm;
    assign calm = (next_item >= quiet_from) && (next_item < quiet_to);

    // ------------------------------------------------------------------
    // decoder predictor: its own copy of the reference state
    // ------------------------------------------------------------------
    logic [7:0]  name_buf [HOLD_CAP];
    int unsigned name_len = 0;
    bit          ref_open = 1'b0;
    logic [7:0]  step_out[$];
    logic [7:0]  rescan_bytes[$];

    function automatic void put_byte(logic [7:0] b);
        // the output buffer of one step is bounded
        if (step_out.size() < OUT_CAP)
            step_out.push_back(b);
    endfunction

    function automatic bit held_is(string s);
        int i;
        if (name_len != s.len())
            return 1'b0;
        for (i = 0; i < s.len(); i++)
        begin
            if (name_buf[i] != s[i])
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int digit_of(logic [7:0] c, int unsigned radix);
        if (c >= "0" && c <= "9")
            return int'(c) - int'("0");
        if (radix == 16 && c >= "a" && c <= "f")
            return int'(c) - int'("a") + 10;
        if (radix == 16 && c >= "A" && c <= "F")
            return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void put_code_point(logic [31:0] cp);
        if (cp > 0 && cp < 32'h80)
        begin
            put_byte(cp[7:0]);
        end
        else if (cp >= 32'h80 && cp <= 32'h7FF)
        begin
            put_byte({3'b110, cp[10:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else if (cp >= 32'hD800 && cp <= 32'hDFFF)
        begin
            // surrogates become the replacement character
            put_byte(8'hEF);
            put_byte(8'hBF);
            put_byte(8'hBD);
        end
        else if (cp >= 32'h800 && cp <= 32'hFFFF)
        begin
            put_byte({4'b1110, cp[15:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else if (cp >= 32'h10000 && cp <= CP_LIMIT)
        begin
            put_byte({5'b11110, cp[20:18]});
            put_byte({2'b10, cp[17:12]});
            put_byte({2'b10, cp[11:6]});
            put_byte({2'b10, cp[5:0]});
        end
        else
        begin
            put_byte(QMARK_CHAR);
        end
    endfunction

    // resolve the held name at ';', 0 when the name is unknown
    function automatic bit resolve_name();
        int unsigned idx;
        int unsigned radix;
        int          d;
        logic [31:0] cp;
        idx   = 1;
        radix = 10;
        cp    = '0;
        if (held_is("lt"))   begin put_byte("<");  return 1'b1; end
        if (held_is("gt"))   begin put_byte(">");  return 1'b1; end
        if (held_is("amp"))  begin put_byte("&");  return 1'b1; end
        if (held_is("quot")) begin put_byte("\""); return 1'b1; end
        if (held_is("apos")) begin put_byte("'");  return 1'b1; end
        if (held_is("nbsp")) begin put_byte(" ");  return 1'b1; end
        if (name_len < 1 || name_buf[0] != HASH_CHAR)
            return 1'b0;
        if (name_len >= 2 && (name_buf[1] == X_LOWER || name_buf[1] == X_UPPER))
        begin
            radix = 16;
            idx   = 2;
        end
        while (idx < name_len && idx < HOLD_CAP)
        begin
            d = digit_of(name_buf[idx], radix);
            if (d < 0)
                break;
            cp = cp * radix + d;
            if (cp > CP_LIMIT)
                cp = CP_SATURATED;
            idx++;
        end
        put_code_point(cp);
        return 1'b1;
    endfunction

    // give up the open reference: '&' goes out, held bytes are scanned again first
    function automatic void abandon_reference(logic [7:0] extra, bit has_extra);
        logic [7:0]  replay[$];
        int          i;
        int unsigned n;
        n = (name_len < HOLD_CAP) ? name_len : HOLD_CAP;
        for (i = 0; i < int'(n); i++)
            replay.push_back(name_buf[i]);
        if (has_extra)
            replay.push_back(extra);
        ref_open = 1'b0;
        name_len = 0;
        put_byte(AMP_CHAR);
        for (i = replay.size() - 1; i >= 0; i--)
            rescan_bytes.push_front(replay[i]);
    endfunction

    function automatic void scan_byte(logic [7:0] b);
        if (!ref_open)
        begin
            if (b == AMP_CHAR)
            begin
                ref_open = 1'b1;
                name_len = 0;
            end
            else
            begin
                put_byte(b);
            end
        end
        else if (b == SEMI_CHAR)
        begin
            if (resolve_name())
            begin
                ref_open = 1'b0;
                name_len = 0;
            end
            else
            begin
                abandon_reference(b, 1'b1);
            end
        end
        else if (b == NUL_CHAR)
        begin
            abandon_reference(b, 1'b1);
        end
        else
        begin
            if (name_len < HOLD_CAP)
            begin
                name_buf[name_len] = b;
                name_len++;
            end
            if (name_len >= HOLD_CAP)
                abandon_reference(NUL_CHAR, 1'b0);
        end
    endfunction

    // output bytes caused by one text transaction land in step_out
    function automatic void decode_text_byte(logic [7:0] value, logic eot);
        bit settled;
        step_out.delete();
        rescan_bytes.delete();
        rescan_bytes.push_back(value);
        settled = 1'b0;
        while (!settled)
        begin
            while (rescan_bytes.size() != 0)
                scan_byte(rescan_bytes.pop_front());
            // end of text keeps failing the open reference until nothing is held
            if (eot && ref_open)
                abandon_reference(NUL_CHAR, 1'b0);
            else
                settled = 1'b1;
        end
    endfunction

    // expected output of an accepted transaction goes onto the scoreboard
    function automatic void accept_item(text_item_t item);
        decoded_byte_t d;
        int            i;
        int            n;
        decode_text_byte(item.value, item.eot);
        if (item.eot)
            streams++;
        n = (item.n_known == BY_MODEL) ? step_out.size() : item.n_known;
        for (i = 0; i < n; i++)
        begin
            d.value = (item.n_known == BY_MODEL) ? step_out[i] : item.known[23 - 8 * i -: 8];
            d.last  = (i == n - 1);
            d.done  = d.last && item.eot;
            pending_output.push_back(d);
        end
    endfunction

    function automatic void check_result();
        decoded_byte_t want;
        results_checked++;
        if (pending_output.size() == 0)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("unexpected output byte %02h last %0b done %0b",
                         out_byte, last, stream_done);
        end
        else
        begin
            want = pending_output.pop_front();
            if (want.value !== out_byte || want.last !== last || want.done !== stream_done)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("output %0d: expected %02h/%0b/%0b, got %02h/%0b/%0b",
                             results_checked, want.value, want.last, want.done,
                             out_byte, last, stream_done);
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // stimulus building
    // ------------------------------------------------------------------
    function automatic void add_row(logic [7:0] value, logic eot, int n_known,
                                    logic [23:0] known);
        text_item_t item;
        item.value   = value;
        item.eot     = eot;
        item.n_known = n_known;
        item.known   = known;
        stim.push_back(item);
    endfunction

    function automatic void push_text(string s, bit mixed_case);
        int         i;
        logic [7:0] c;
        for (i = 0; i < s.len(); i++)
        begin
            c = s[i];
            if (mixed_case && c >= "a" && c <= "f" && $urandom_range(1) == 1)
                c = c & ~CASE_BIT;
            seq_bytes.push_back(c);
        end
    endfunction

    function automatic string known_name(int unsigned k);
        case (k)
            0:       return "lt";
            1:       return "gt";
            2:       return "amp";
            3:       return "quot";
            4:       return "apos";
            default: return "nbsp";
        endcase
    endfunction

    // code points spread over every utf-8 length, surrogates and zero
    function automatic logic [31:0] random_code_point();
        case ($urandom_range(6))
            0:       return 32'h0;
            1:       return 32'($urandom_range(32'h7F, 32'h1));
            2:       return 32'($urandom_range(32'h7FF, 32'h80));
            3:       return 32'($urandom_range(32'hFFFF, 32'h800));
            4:       return 32'($urandom_range(32'hDFFF, 32'hD800));
            default: return 32'($urandom_range(32'h10FFFF, 32'h10000));
        endcase
    endfunction

    function automatic seq_kind_t pick_kind();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 15) return SEQ_PLAIN;
        if (roll < 35) return SEQ_NAMED;
        if (roll < 50) return SEQ_DECIMAL;
        if (roll < 65) return SEQ_HEX;
        if (roll < 73) return SEQ_TRAILING;
        if (roll < 80) return SEQ_UNKNOWN;
        if (roll < 85) return SEQ_OVERFLOW;
        if (roll < 90) return SEQ_NUL;
        if (roll < 95) return SEQ_CUT;
        return SEQ_HUGE;
    endfunction

    // half well-formed references with random content, the rest noise and breakage
    function automatic void add_random_sequence();
        seq_kind_t   kind;
        int unsigned n;
        int          i;
        logic [7:0]  c;
        logic [31:0] cp;
        bit          end_here;
        seq_bytes.delete();
        end_here = 1'b0;
        kind = pick_kind();
        case (kind)
            SEQ_PLAIN:
            begin
                n = $urandom_range(4, 1);
                for (i = 0; i < int'(n); i++)
                    seq_bytes.push_back(8'($urandom_range(255)));
            end
            SEQ_NAMED:
            begin
                seq_bytes.push_back(AMP_CHAR);
                push_text(known_name($urandom_range(5)), 1'b0);
                seq_bytes.push_back(SEMI_CHAR);
            end
            SEQ_DECIMAL:
            begin
                cp = random_code_point();
                seq_bytes.push_back(AMP_CHAR);
                seq_bytes.push_back(HASH_CHAR);
                if ($urandom_range(3) == 0)
                    seq_bytes.push_back("0");
                push_text($sformatf("%0d", cp), 1'b0);
                seq_bytes.push_back(SEMI_CHAR);
            end
            SEQ_HEX:
            begin
                cp = random_code_point();
                seq_bytes.push_back(AMP_CHAR);
                seq_bytes.push_back(HASH_CHAR);
                seq_bytes.push_back(($urandom_range(1) == 1) ? X_UPPER : X_LOWER);
                if ($urandom_range(3) == 0)
                    seq_bytes.push_back("0");
                push_text($sformatf("%0h", cp), 1'b1);
                seq_bytes.push_back(SEMI_CHAR);
            end
            SEQ_TRAILING:
            begin
                // junk between the digits and ';' is dropped
                cp = 32'($urandom_range(32'h7FF, 32'h1));
                seq_bytes.push_back(AMP_CHAR);
                seq_bytes.push_back(HASH_CHAR);
                push_text($sformatf("%0d", cp), 1'b0);
                n = $urandom_range(3, 1);
                for (i = 0; i < int'(n); i++)
                    seq_bytes.push_back(8'($urandom_range("w", "g")));
                seq_bytes.push_back(SEMI_CHAR);
            end
            SEQ_UNKNOWN:
            begin
                seq_bytes.push_back(AMP_CHAR);
                n = $urandom_range(6, 1);
                for (i = 0; i < int'(n); i++)
                    seq_bytes.push_back(8'($urandom_range("z", "a")));
                seq_bytes.push_back(SEMI_CHAR);
            end
            SEQ_OVERFLOW:
            begin
                // no ';' inside the window
                seq_bytes.push_back(AMP_CHAR);
                for (i = 0; i < HOLD_CAP; i++)
                begin
                    c = 8'($urandom_range(255, 1));
                    if (c == SEMI_CHAR)
                        c = "k";
                    seq_bytes.push_back(c);
                end
            end
            SEQ_NUL:
            begin
                seq_bytes.push_back(AMP_CHAR);
                n = $urandom_range(3);
                for (i = 0; i < int'(n); i++)
                    seq_bytes.push_back(8'($urandom_range("z", "a")));
                seq_bytes.push_back(NUL_CHAR);
            end
            SEQ_CUT:
            begin
                // stream ends with the reference still open
                seq_bytes.push_back(AMP_CHAR);
                if ($urandom_range(1) == 1)
                    seq_bytes.push_back(HASH_CHAR);
                n = $urandom_range(3);
                for (i = 0; i < int'(n); i++)
                    seq_bytes.push_back(8'($urandom_range("z", "0")));
                end_here = 1'b1;
            end
            default:
            begin
                // numbers past the top code point saturate
                seq_bytes.push_back(AMP_CHAR);
                seq_bytes.push_back(HASH_CHAR);
                if ($urandom_range(1) == 1)
                begin
                    seq_bytes.push_back("9");
                    n = $urandom_range(8, 6);
                    for (i = 0; i < int'(n); i++)
                        seq_bytes.push_back(8'($urandom_range("9", "0")));
                end
                else
                begin
                    seq_bytes.push_back(X_LOWER);
                    seq_bytes.push_back("1");
                    n = $urandom_range(7, 6);
                    for (i = 0; i < int'(n); i++)
                        push_text($sformatf("%0h", $urandom_range(15)), 1'b1);
                end
                seq_bytes.push_back(SEMI_CHAR);
            end
        endcase
        if ($urandom_range(11) == 0)
            end_here = 1'b1;
        for (i = 0; i < seq_bytes.size(); i++)
            add_row(seq_bytes[i], end_here && (i == seq_bytes.size() - 1), BY_MODEL, 24'h0);
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and watchdog
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d output bytes still expected",
                 cycles, pending_output.size());
        $display("html_entity_to_utf8_decoder_test NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // result side: random stall, one long hold-off, checks every transaction
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int holdoff_left;
        bit holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
                check_result();
            // long hold-off so the decoder fills up and stalls its text input
            if (!holdoff_done && next_item >= holdoff_at)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                holdoff_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // ------------------------------------------------------------------
    // text side: directed table, then random references; ends the run
    // ------------------------------------------------------------------
    initial
    begin : text_source
        text_item_t cur;
        bit         paused_done;
        paused_done = 1'b0;
        text_valid  <= 1'b0;
        text_byte   <= 8'h00;
        end_of_text <= 1'b0;

        // a plain letter and the top byte value
        add_row("A",   1'b0, 1, {"A", 16'h0});
        add_row(8'hFF, 1'b0, 1, {8'hFF, 16'h0});
        // empty digits decode to '?'
        add_row(AMP_CHAR,  1'b0, BY_MODEL, 24'h0);
        add_row(HASH_CHAR, 1'b0, BY_MODEL, 24'h0);
        add_row(SEMI_CHAR, 1'b0, 1, {QMARK_CHAR, 16'h0});
        // named reference
        add_row(AMP_CHAR,  1'b0, BY_MODEL, 24'h0);
        add_row("l",       1'b0, BY_MODEL, 24'h0);
        add_row("t",       1'b0, BY_MODEL, 24'h0);
        add_row(SEMI_CHAR, 1'b0, 1, {"<", 16'h0});
        // unknown name, ';' is rescanned as text
        add_row(AMP_CHAR,  1'b0, BY_MODEL, 24'h0);
        add_row("a",       1'b0, BY_MODEL, 24'h0);
        add_row(SEMI_CHAR, 1'b0, 3, {AMP_CHAR, "a", SEMI_CHAR});
        // zero byte inside a reference
        add_row(AMP_CHAR,  1'b0, BY_MODEL, 24'h0);
        add_row("b",       1'b0, BY_MODEL, 24'h0);
        add_row(NUL_CHAR,  1'b0, 3, {AMP_CHAR, "b", NUL_CHAR});
        // end of text with a reference open
        add_row(AMP_CHAR,  1'b1, 1, {AMP_CHAR, 16'h0});
        // top surrogate becomes the replacement character
        add_row(AMP_CHAR,  1'b0, BY_MODEL, 24'h0);
        add_row(HASH_CHAR, 1'b0, BY_MODEL, 24'h0);
        add_row(X_LOWER,   1'b0, BY_MODEL, 24'h0);
        add_row("d",       1'b0, BY_MODEL, 24'h0);
        add_row("f",       1'b0, BY_MODEL, 24'h0);
        add_row("f",       1'b0, BY_MODEL, 24'h0);
        add_row("f",       1'b0, BY_MODEL, 24'h0);
        add_row(SEMI_CHAR, 1'b0, 3, 24'hEFBFBD);
        directed_count = stim.size();

        while (stim.size() < directed_count + RANDOM_ITEMS)
            add_random_sequence();
        holdoff_at = directed_count + 30;
        quiet_from = directed_count + 50;
        quiet_to   = directed_count + 90;
        pause_at   = directed_count + 110;

        @(posedge clk);
        while (!rst_n)
            @(posedge clk);

        while (next_item < stim.size())
        begin
            @(posedge clk);
            if (text_valid && !text_stall)
            begin
                accept_item(stim[next_item]);
                next_item++;
            end
            // a stalled transaction stays as it is
            if (!(text_valid && text_stall))
            begin
                // one pause until every expected byte has come out
                if (next_item == pause_at && pending_output.size() == 0)
                    paused_done = 1'b1;
                if (next_item < stim.size() && !(next_item == pause_at && !paused_done)
                    && (calm || $urandom_range(99) >= IDLE_PERCENT))
                begin
                    cur = stim[next_item];
                    text_valid  <= 1'b1;
                    text_byte   <= cur.value;
                    end_of_text <= cur.eot;
                end
                else
                begin
                    text_valid <= 1'b0;
                end
            end
        end

        while (pending_output.size() != 0)
            @(posedge clk);
        // a reference with no output may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d text transactions (%0d directed) in %0d streams, %0d output bytes checked",
                 next_item, directed_count, streams, results_checked);
        $display("named, decimal, hex, surrogate, oversized, window-full, zero-byte and cut-off"
                 , " references exercised; %0d mismatches", mismatches);
        if (mismatches == 0 && pending_output.size() == 0)
            $display("html_entity_to_utf8_decoder_test OK");
        else
            $display("html_entity_to_utf8_decoder_test NOT OK");
        $finish;
    end

endmodule
